[rtl/msd_pkg.sv]
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants for the mean / std deviation block
// Word layouts, internal widths and the engine state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

    localparam int SAMPLE_W    = 24;  // sample field width
    localparam int CNT_W       = 11;  // count field, holds 0..1024
    localparam int SUM_W       = 34;  // 1024 * (2^24-1) fits
    localparam int SQ_W        = 58;  // 1024 * (2^24-1)^2 fits
    localparam int RES_W       = 32;  // mean / deviation field width
    localparam int PROD_A_W    = 29;  // multiplier operand A
    localparam int PROD_B_W    = 17;  // multiplier operand B
    localparam int PROD_W      = PROD_A_W + PROD_B_W;
    localparam int ACC_W       = 69;  // n*sumsq and sum^2
    localparam int VAR_W       = 86;  // (n*sumsq - sum^2) << 16, rounded up to even
    localparam int ROOT_W      = VAR_W / 2;
    localparam int SQREM_W     = ROOT_W + 3;
    localparam int DVD_W       = 43;  // dividend / quotient register
    localparam int ITER_W      = 6;
    localparam int MUL_STEPS   = 5;   // partial products
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int DIV_STEPS   = DVD_W;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                sample_valid;
        logic                last;
    } msd_in_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [RES_W-1:0] mean_fixed;
        logic [RES_W-1:0] stddev_fixed;
        logic             overflow;
    } msd_out_t;

    // One closed set handed from the accumulator to the engine
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sumsq;
        logic             overflow;
    } msd_set_t;

    typedef struct packed {
        logic     en;
        msd_set_t data;
    } msd_qwr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_SQRT,
        ST_DIV_MEAN,
        ST_DIV_SD,
        ST_DONE
    } msd_state_t;

endpackage

`default_nettype wire

[rtl/msd_front.sv]
// ----------------------------------------------------------------------------
// msd_front: sample accumulator
// Takes one word per cycle while accept is high, keeps count / sum / sum of
// squares and hands a closed set to the queue on last.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_front #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire msd_pkg::msd_in_t item,
    output msd_pkg::msd_qwr_t     qwr
);

    localparam logic [msd_pkg::SAMPLE_W-1:0] MASK =
        msd_pkg::SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);

    logic [msd_pkg::CNT_W-1:0] count_reg, count_next;
    logic [msd_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [msd_pkg::SQ_W-1:0]  sq_reg, sq_next;
    logic                      drop_reg, drop_next;

    logic [msd_pkg::SAMPLE_W-1:0]   s;
    logic [2*msd_pkg::SAMPLE_W-1:0] s_sq;
    logic                           room, take;

    assign s    = item.sample & MASK;
    assign s_sq = s * s;
    assign room = count_reg < msd_pkg::CNT_W'(MAX_SAMPLES);
    assign take = accept && item.sample_valid && room;

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sq_next    = sq_reg;
        drop_next  = drop_reg;
        if (take)
        begin
            count_next = count_reg + 1'b1;
            sum_next   = sum_reg + msd_pkg::SUM_W'(s);
            sq_next    = sq_reg + msd_pkg::SQ_W'(s_sq);
        end
        else if (accept && item.sample_valid)
        begin
            drop_next = 1'b1;
        end
    end

    always_comb
    begin
        qwr.en            = accept && item.last;
        qwr.data.count    = count_next;
        qwr.data.sum      = sum_next;
        qwr.data.sumsq    = sq_next;
        qwr.data.overflow = drop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            drop_reg  <= 1'b0;
        end
        else if (accept && item.last)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            sq_reg    <= sq_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

`default_nettype wire

[rtl/msd_queue.sv]
// ----------------------------------------------------------------------------
// msd_queue: closed-set queue
// Two-entry FIFO between the accumulator and the statistics engine.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire msd_pkg::msd_qwr_t qwr,
    input  wire logic              rd,
    output msd_pkg::msd_set_t      head,
    output logic                   q_full,
    output logic                   q_empty
);

    localparam int PTR_W = $clog2(msd_pkg::QUEUE_DEPTH);

    msd_pkg::msd_set_t mem_reg [msd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wp_reg, rp_reg;
    logic [PTR_W:0]    fill_reg;

    logic do_wr, do_rd;

    assign q_full  = fill_reg == (PTR_W+1)'(msd_pkg::QUEUE_DEPTH);
    assign q_empty = fill_reg == '0;
    assign do_wr   = qwr.en && !q_full;
    assign do_rd   = rd && !q_empty;
    assign head    = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= qwr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            fill_reg <= fill_reg + (PTR_W+1)'(do_wr) - (PTR_W+1)'(do_rd);
        end
    end

endmodule

`default_nettype wire

[rtl/msd_back.sv]
// ----------------------------------------------------------------------------
// msd_back: statistics engine
// Partial-product multiplier, digit-by-digit square root and a shared
// restoring divider turn one closed set into a result word.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_back #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire msd_pkg::msd_set_t head,
    output logic                   q_pop,
    input  wire logic              pop,
    output logic                   empty,
    output msd_pkg::msd_out_t      result
);

    msd_pkg::msd_state_t state_reg, state_next;

    logic [msd_pkg::ITER_W-1:0] iter_reg;

    msd_pkg::msd_set_t job_reg;

    logic [msd_pkg::PROD_W-1:0]  prod_reg;
    logic [msd_pkg::ACC_W-1:0]   acc_a_reg, acc_b_reg;
    logic [msd_pkg::VAR_W-1:0]   var_reg;
    logic [msd_pkg::SQREM_W-1:0] sqrem_reg;
    logic [msd_pkg::ROOT_W-1:0]  root_reg;
    logic [msd_pkg::DVD_W-1:0]   dvd_reg;
    logic [msd_pkg::CNT_W-1:0]   drem_reg;
    logic [msd_pkg::RES_W-1:0]   mean_reg, sd_reg;

    msd_pkg::msd_out_t res_reg;
    logic              res_valid_reg;
    logic              res_load;

    // multiplier operands
    logic [msd_pkg::PROD_A_W-1:0] op_a;
    logic [msd_pkg::PROD_B_W-1:0] op_b;

    // square root step
    logic [msd_pkg::SQREM_W+1:0] sq_rs, sq_trial;
    logic                        sq_ge;

    // divider step
    logic [msd_pkg::CNT_W:0]   dv_r;
    logic                      dv_ge;
    logic [msd_pkg::DVD_W-1:0] dvd_step;
    logic [msd_pkg::CNT_W-1:0] drem_step;

    logic last_iter_sqrt, last_iter_div;

    assign last_iter_sqrt = iter_reg == msd_pkg::ITER_W'(msd_pkg::SQRT_STEPS - 1);
    assign last_iter_div  = iter_reg == msd_pkg::ITER_W'(msd_pkg::DIV_STEPS - 1);

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (iter_reg)
            6'd0:
            begin
                op_a = job_reg.sumsq[28:0];
                op_b = msd_pkg::PROD_B_W'(job_reg.count);
            end
            6'd1:
            begin
                op_a = job_reg.sumsq[57:29];
                op_b = msd_pkg::PROD_B_W'(job_reg.count);
            end
            6'd2:
            begin
                op_a = msd_pkg::PROD_A_W'(job_reg.sum[16:0]);
                op_b = job_reg.sum[16:0];
            end
            6'd3:
            begin
                op_a = msd_pkg::PROD_A_W'(job_reg.sum[16:0]);
                op_b = job_reg.sum[33:17];
            end
            6'd4:
            begin
                op_a = msd_pkg::PROD_A_W'(job_reg.sum[33:17]);
                op_b = job_reg.sum[33:17];
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign sq_rs    = {sqrem_reg, var_reg[msd_pkg::VAR_W-1 -: 2]};
    assign sq_trial = (msd_pkg::SQREM_W+2)'({root_reg, 2'b01});
    assign sq_ge    = sq_rs >= sq_trial;

    assign dv_r      = {drem_reg, dvd_reg[msd_pkg::DVD_W-1]};
    assign dv_ge     = dv_r >= {1'b0, job_reg.count};
    assign drem_step = dv_ge ? msd_pkg::CNT_W'(dv_r - {1'b0, job_reg.count})
                             : msd_pkg::CNT_W'(dv_r);
    assign dvd_step  = {dvd_reg[msd_pkg::DVD_W-2:0], dv_ge};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msd_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (head.count == '0) ? msd_pkg::ST_DONE : msd_pkg::ST_MUL;
                end
            end
            msd_pkg::ST_MUL:
            begin
                if (iter_reg == msd_pkg::ITER_W'(msd_pkg::MUL_STEPS))
                begin
                    state_next = msd_pkg::ST_SUB;
                end
            end
            msd_pkg::ST_SUB:
            begin
                state_next = msd_pkg::ST_SQRT;
            end
            msd_pkg::ST_SQRT:
            begin
                if (last_iter_sqrt)
                begin
                    state_next = msd_pkg::ST_DIV_MEAN;
                end
            end
            msd_pkg::ST_DIV_MEAN:
            begin
                if (last_iter_div)
                begin
                    state_next = msd_pkg::ST_DIV_SD;
                end
            end
            msd_pkg::ST_DIV_SD:
            begin
                if (last_iter_div)
                begin
                    state_next = msd_pkg::ST_DONE;
                end
            end
            msd_pkg::ST_DONE:
            begin
                if (res_load)
                begin
                    state_next = msd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msd_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop    = (state_reg == msd_pkg::ST_IDLE) && !q_empty;
        res_load = (state_reg == msd_pkg::ST_DONE) && (!res_valid_reg || pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msd_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            msd_pkg::ST_IDLE:
            begin
                job_reg   <= head;
                iter_reg  <= '0;
                acc_a_reg <= '0;
                acc_b_reg <= '0;
                mean_reg  <= '0;
                sd_reg    <= '0;
            end
            msd_pkg::ST_MUL:
            begin
                prod_reg <= op_a * op_b;
                iter_reg <= iter_reg + 1'b1;
                case (iter_reg)
                    6'd1: acc_a_reg <= acc_a_reg + msd_pkg::ACC_W'(prod_reg);
                    6'd2: acc_a_reg <= acc_a_reg + (msd_pkg::ACC_W'(prod_reg) << 29);
                    6'd3: acc_b_reg <= acc_b_reg + msd_pkg::ACC_W'(prod_reg);
                    6'd4: acc_b_reg <= acc_b_reg + (msd_pkg::ACC_W'(prod_reg) << 18);
                    6'd5: acc_b_reg <= acc_b_reg + (msd_pkg::ACC_W'(prod_reg) << 34);
                    default: ;
                endcase
            end
            msd_pkg::ST_SUB:
            begin
                // sum^2 never exceeds n*sumsq for a real set; guard anyway
                if (acc_b_reg <= acc_a_reg)
                begin
                    var_reg <= msd_pkg::VAR_W'(acc_a_reg - acc_b_reg) << (2 * FRAC_BITS);
                end
                else
                begin
                    var_reg <= '0;
                end
                sqrem_reg <= '0;
                root_reg  <= '0;
                iter_reg  <= '0;
            end
            msd_pkg::ST_SQRT:
            begin
                var_reg   <= var_reg << 2;
                sqrem_reg <= sq_ge ? msd_pkg::SQREM_W'(sq_rs - sq_trial)
                                   : msd_pkg::SQREM_W'(sq_rs);
                root_reg  <= {root_reg[msd_pkg::ROOT_W-2:0], sq_ge};
                iter_reg  <= iter_reg + 1'b1;
                if (last_iter_sqrt)
                begin
                    iter_reg <= '0;
                    dvd_reg  <= msd_pkg::DVD_W'(job_reg.sum) << FRAC_BITS;
                    drem_reg <= '0;
                end
            end
            msd_pkg::ST_DIV_MEAN:
            begin
                dvd_reg  <= dvd_step;
                drem_reg <= drem_step;
                iter_reg <= iter_reg + 1'b1;
                if (last_iter_div)
                begin
                    mean_reg <= dvd_step[msd_pkg::RES_W-1:0];
                    iter_reg <= '0;
                    dvd_reg  <= msd_pkg::DVD_W'(root_reg);
                    drem_reg <= '0;
                end
            end
            msd_pkg::ST_DIV_SD:
            begin
                dvd_reg  <= dvd_step;
                drem_reg <= drem_step;
                iter_reg <= iter_reg + 1'b1;
                if (last_iter_div)
                begin
                    sd_reg <= dvd_step[msd_pkg::RES_W-1:0];
                end
            end
            msd_pkg::ST_DONE:
            begin
                if (res_load)
                begin
                    res_reg.count        <= job_reg.count;
                    res_reg.mean_fixed   <= mean_reg;
                    res_reg.stddev_fixed <= sd_reg;
                    res_reg.overflow     <= job_reg.overflow;
                end
            end
            default: ;
        endcase
    end

    assign empty  = !res_valid_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

[rtl/sample_mean_and_std_deviation.sv]
// ----------------------------------------------------------------------------
// sample_mean_and_std_deviation: running mean and population std deviation
// Accumulates unsigned samples and reports count, mean and deviation per set.
// ----------------------------------------------------------------------------
// Push one word per cycle: samples with sample_valid set are added to the
// running count, sum and sum of squares, and a word with last set closes the
// set (its own sample counted first). Sample taking runs at one word per
// clock while full is low; full rises only while two closed sets wait for
// the statistics engine. The engine takes one set at a time through a load,
// the partial-product multiplier, a subtract, the square root and the shared
// restoring divider (mean, then deviation), then writes the result register.
// Results come out in set order through the empty / pop side; a finished
// result waits in its register while the accumulator and the engine go on,
// the engine only up to the end of the next set. Results are floor(sum*2^F/n)
// and floor(isqrt(2^2F*(n*sumsq - sum^2))/n), truncated to 32 bits; an empty
// set gives zeros. Samples past MAX_SAMPLES are dropped and flagged.
`default_nettype none

module sample_mean_and_std_deviation #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire msd_pkg::msd_in_t item,
    output logic                  empty,
    input  wire logic             pop,
    output msd_pkg::msd_out_t     result
);

    msd_pkg::msd_qwr_t qwr;
    msd_pkg::msd_set_t head;
    logic              q_full, q_empty, q_pop;
    logic              accept;

    // conservative: hold off new words whenever the set queue is full
    assign full   = q_full;
    assign accept = push && !q_full;

    msd_front #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .item  (item),
        .qwr   (qwr)
    );

    msd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .qwr    (qwr),
        .rd     (q_pop),
        .head   (head),
        .q_full (q_full),
        .q_empty(q_empty)
    );

    msd_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_empty(q_empty),
        .head   (head),
        .q_pop  (q_pop),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

endmodule

`default_nettype wire

[rtl/msd_checker.sv]
// ----------------------------------------------------------------------------
// msd_checker: port-level checks for the mean / std deviation block
// Watches the result side only; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_checker #(
    parameter int MAX_SAMPLES = 1024
) (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              empty,
    input wire logic              pop,
    input wire msd_pkg::msd_out_t result
);

    // a waiting result stays put until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed or vanished before pop");

    // an empty set reports zero statistics
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.count == '0) |->
        (result.mean_fixed == '0 && result.stddev_fixed == '0))
        else $error("empty set with nonzero statistics");

    // count never exceeds the limit, and drops only happen at the limit
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.count <= msd_pkg::CNT_W'(MAX_SAMPLES) &&
                    (!result.overflow || result.count == msd_pkg::CNT_W'(MAX_SAMPLES))))
        else $error("count or overflow inconsistent with sample limit");

    // a lone sample has zero deviation
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.count == msd_pkg::CNT_W'(1)) |-> result.stddev_fixed == '0)
        else $error("single sample with nonzero deviation");

endmodule

bind sample_mean_and_std_deviation msd_checker #(
    .MAX_SAMPLES(MAX_SAMPLES)
) u_msd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .empty (empty),
    .pop   (pop),
    .result(result)
);

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sample_mean_and_std_deviation
// Pushes runs of samples through the input queue side, predicts the count,
// mean and population deviation of every closed set, and pops and checks
// each result word in order under several idle and stall mixes.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int MAX_SAMPLES  = 1024;
    localparam int SAMPLE_BITS  = 24;
    localparam int FRAC_BITS    = 8;
    localparam int RESET_CYCLES = 7;
    // Wait a good margin past the engine's work on one set at the end
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int SHOWN_ERRORS = 10;

    localparam logic [msd_pkg::SAMPLE_W-1:0] SAMPLE_MAX  = '1;
    localparam logic [msd_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
        msd_pkg::SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              push  = 1'b0;
    logic              pop   = 1'b0;
    msd_pkg::msd_in_t  item  = '0;
    logic              full;
    logic              empty;
    msd_pkg::msd_out_t result;

    // Idle / stall mix, in percent of cycles
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    // Cycles left in a forced receiver hold-off
    int pop_holdoff   = 0;

    int cycle_count   = 0;
    int mismatches    = 0;

    // Predictor state: the set being accumulated
    logic [msd_pkg::CNT_W-1:0] set_count   = '0;
    logic [msd_pkg::SUM_W-1:0] set_sum     = '0;
    logic [msd_pkg::SQ_W-1:0]  set_sumsq   = '0;
    logic                      set_dropped = 1'b0;

    // Statistics words still owed by the block, oldest first
    msd_pkg::msd_out_t pending_stats[$];

    sample_mean_and_std_deviation #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit; a hang ends here
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sample_mean_and_std_deviation: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Bitwise integer square root, 64-bit root of a 128-bit radicand
    function automatic logic [63:0] isqrt_wide(logic [127:0] x);
        logic [63:0]  root;
        logic [63:0]  trial;
        logic [127:0] trial_w;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            trial   = root | (64'd1 << b);
            trial_w = 128'(trial);
            if (trial_w * trial_w <= x)
                root = trial;
        end
        return root;
    endfunction

    // Statistics word for the set held in the predictor
    function automatic msd_pkg::msd_out_t close_set_stats();
        msd_pkg::msd_out_t stats;
        logic [127:0]      n_w;
        logic [127:0]      sum_w;
        logic [127:0]      sumsq_w;
        logic [127:0]      n_sumsq;
        logic [127:0]      sum_sq;
        logic [127:0]      scaled_var;
        logic [127:0]      mean_w;
        logic [127:0]      dev_w;
        stats   = '0;
        n_w     = 128'(set_count);
        sum_w   = 128'(set_sum);
        sumsq_w = 128'(set_sumsq);
        if (set_count != 0)
        begin
            mean_w  = (sum_w << FRAC_BITS) / n_w;
            n_sumsq = n_w * sumsq_w;
            sum_sq  = sum_w * sum_w;
            dev_w   = '0;
            // n*sumsq >= sum^2 always; kept as a guard, as in the hardware
            if (sum_sq <= n_sumsq)
            begin
                scaled_var = (n_sumsq - sum_sq) << (2 * FRAC_BITS);
                dev_w      = 128'(isqrt_wide(scaled_var));
                dev_w      = dev_w / n_w;
            end
            stats.mean_fixed   = mean_w[msd_pkg::RES_W-1:0];
            stats.stddev_fixed = dev_w[msd_pkg::RES_W-1:0];
        end
        stats.count    = set_count;
        stats.overflow = set_dropped;
        return stats;
    endfunction

    // One accepted input word into the running set
    function automatic void absorb_word(msd_pkg::msd_in_t w);
        logic [msd_pkg::SQ_W-1:0] s;
        s = msd_pkg::SQ_W'(w.sample & SAMPLE_MASK);
        if (w.sample_valid)
        begin
            if (set_count < MAX_SAMPLES)
            begin
                set_count = set_count + 1'b1;
                set_sum   = set_sum + msd_pkg::SUM_W'(s);
                set_sumsq = set_sumsq + s * s;
            end
            else
                set_dropped = 1'b1;   // set full: sample dropped, flag it
        end
        if (w.last)
        begin
            pending_stats.push_back(close_set_stats());
            set_count   = '0;
            set_sum     = '0;
            set_sumsq   = '0;
            set_dropped = 1'b0;
        end
    endfunction

    // Compare one popped word with the oldest expected one
    function automatic void check_stats(msd_pkg::msd_out_t got);
        msd_pkg::msd_out_t want;
        if (pending_stats.size() == 0)
        begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
                $display("%0t: unexpected stats word count=%0d mean=%h sd=%h ovf=%b",
                         $time, got.count, got.mean_fixed, got.stddev_fixed,
                         got.overflow);
            return;
        end
        want = pending_stats.pop_front();
        if (got.count !== want.count || got.mean_fixed !== want.mean_fixed ||
            got.stddev_fixed !== want.stddev_fixed || got.overflow !== want.overflow)
        begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
                $display({"%0t: stats exp count=%0d mean=%h sd=%h ovf=%b,",
                          " got count=%0d mean=%h sd=%h ovf=%b"},
                         $time, want.count, want.mean_fixed, want.stddev_fixed,
                         want.overflow, got.count, got.mean_fixed,
                         got.stddev_fixed, got.overflow);
        end
    endfunction

    // Both handshakes are seen at the edge, before this edge's drive updates
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            check_stats(result);
        if (rst_n && push && !full)
            absorb_word(item);
    end

    // ------------------------------------------------------------------------
    // Receiver: random pop, or a counted hold-off when one is requested
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (pop_holdoff > 0)
        begin
            pop_holdoff = pop_holdoff - 1;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Sender: one word per call. Called right after a rising edge; returns at
    // the edge that took the word, with push still high so that a following
    // word goes out back to back without push dropping in between.
    // ------------------------------------------------------------------------
    task automatic send_word(logic [msd_pkg::SAMPLE_W-1:0] s, logic v, logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push              <= 1'b1;
        item.sample       <= s;
        item.sample_valid <= v;
        item.last         <= l;
        do
            @(posedge clk);
        while (full);
    endtask

    // Random sample in one of a few value families
    function automatic logic [msd_pkg::SAMPLE_W-1:0] pick_sample(
        int family, logic [msd_pkg::SAMPLE_W-1:0] base);
        logic [msd_pkg::SAMPLE_W-1:0] s;
        case (family)
            0:       s = msd_pkg::SAMPLE_W'($urandom);
            1:       s = msd_pkg::SAMPLE_W'($urandom_range(255));
            2:       s = base + msd_pkg::SAMPLE_W'($urandom_range(15));  // tight cluster
            default: s = $urandom_range(1) ? SAMPLE_MAX : '0;
        endcase
        return s;
    endfunction

    // One random set; returns the number of words that count toward the run
    task automatic send_random_set(output int words);
        int                           len;
        int                           pick;
        int                           family;
        logic                         close_empty;
        logic [msd_pkg::SAMPLE_W-1:0] base;
        pick        = $urandom_range(99);
        family      = $urandom_range(3);
        base        = msd_pkg::SAMPLE_W'($urandom);
        close_empty = ($urandom_range(4) == 0);
        words       = 0;
        if (pick < 5)
            len = 0;
        else if (pick < 80)
            len = $urandom_range(8, 1);
        else if (pick < 96)
            len = $urandom_range(40, 9);
        else
            len = $urandom_range(64, 41);
        for (int i = 0; i < len; i++)
        begin
            // now and then an ignored word between samples
            if ($urandom_range(9) == 0)
                send_word(msd_pkg::SAMPLE_W'($urandom), 1'b0, 1'b0);
            send_word(pick_sample(family, base), 1'b1, !close_empty && (i == len - 1));
            words++;
        end
        // closing word without a sample; also how an empty set is made
        if (close_empty || len == 0)
        begin
            send_word(msd_pkg::SAMPLE_W'($urandom), 1'b0, 1'b1);
            words++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes and the named corner cases
    task automatic test_directed();
        send_word('0, 1'b0, 1'b1);                 // empty set
        send_word(SAMPLE_MAX, 1'b1, 1'b1);         // one full-scale sample
        send_word('0, 1'b1, 1'b1);                 // one zero sample
        send_word('0, 1'b1, 1'b0);                 // widest two-sample spread
        send_word(SAMPLE_MAX, 1'b1, 1'b1);
        send_word(SAMPLE_MAX, 1'b0, 1'b0);         // ignored word
        send_word(24'd3, 1'b1, 1'b0);
        send_word(24'd4, 1'b1, 1'b0);
        send_word(24'h5A5A5A, 1'b0, 1'b1);         // close without a sample
        send_word(24'd1, 1'b1, 1'b0);
        send_word(24'd2, 1'b1, 1'b0);
        send_word(SAMPLE_MAX, 1'b0, 1'b0);
        send_word(24'd4, 1'b1, 1'b1);
        send_word(24'hAAAAAA, 1'b1, 1'b0);
        send_word(24'h555555, 1'b1, 1'b1);
        send_word(SAMPLE_MAX, 1'b0, 1'b1);         // empty set, ones on sample
    endtask

    // Set filled to its sample ceiling and then run past it
    task automatic test_set_limits();
        // 0 / full scale alternating: count 1024, largest deviation; the
        // extra samples and the closing sample are dropped and the set
        // reports overflow
        for (int i = 0; i < MAX_SAMPLES; i++)
            send_word(i[0] ? SAMPLE_MAX : '0, 1'b1, 1'b0);
        send_word(msd_pkg::SAMPLE_W'($urandom), 1'b1, 1'b0);
        send_word(msd_pkg::SAMPLE_W'($urandom), 1'b1, 1'b0);
        send_word(SAMPLE_MAX, 1'b1, 1'b1);
        // next set must start clean
        send_word(24'd7, 1'b1, 1'b1);
    endtask

    // Random sets under one idle / stall mix
    task automatic test_random_stream(int idle_pct, int stall_pct, int target);
        int sent;
        int words;
        sent          = 0;
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        while (sent < target)
        begin
            send_random_set(words);
            sent += words;
        end
    endtask

    // Receiver holds off long enough that the block fills and stops taking
    // words; the sender keeps offering short sets throughout
    task automatic test_backpressure();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        pop_holdoff   = 2000;
        for (int i = 0; i < 30; i++)
        begin
            send_word(msd_pkg::SAMPLE_W'($urandom), 1'b1, 1'b0);
            send_word(msd_pkg::SAMPLE_W'($urandom), 1'b1, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_set_limits();
        test_random_stream(0, 0, 40);
        test_random_stream(78, 0, 40);
        test_random_stream(0, 78, 40);
        test_random_stream(17, 17, 40);
        test_backpressure();

        push <= 1'b0;
        pop_stall_pct = 0;
        @(posedge clk);
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        // anything still owed at this point was never delivered
        if (mismatches == 0 && pending_stats.size() == 0)
            $display("sample_mean_and_std_deviation: match");
        else
            $display("sample_mean_and_std_deviation: mismatch");
        $finish;
    end

endmodule
